// ===== rtl/lcw_pkg.sv =====
`timescale 1ns / 1ps

package lcw_pkg;

    // field widths of the item and result beats
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int ERR_W   = 10;
    localparam int ADDR_W  = 25;
    localparam int BASE_W  = 24;
    localparam int COLOR_W = 16;

    // item operation codes
    typedef enum logic {
        OP_BEGIN = 1'b0,
        OP_COLOR = 1'b1
    } t_op;

    // classified item as it travels through the queue
    typedef struct packed {
        t_op                op;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [ADDR_W-1:0]  row;
        logic [X_W-1:0]     adx;
        logic [Y_W-1:0]     ady;
        logic               sxn;
        logic               syn;
        logic               xmaj;
        logic [ERR_W-1:0]   err;
        logic [X_W-1:0]     steps;
        logic [COLOR_W-1:0] color;
    } t_cmd;

    // queue flags seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/lcw_front.sv =====
`timescale 1ns / 1ps

module lcw_front #(
    parameter int SCREEN_WIDTH = 320,
    parameter int COLOR_BITS   = 16
) (
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic [lcw_pkg::X_W-1:0]      i_start_x,
    input  logic [lcw_pkg::Y_W-1:0]      i_start_y,
    input  logic [lcw_pkg::X_W-1:0]      i_end_x,
    input  logic [lcw_pkg::Y_W-1:0]      i_end_y,
    input  logic [lcw_pkg::COLOR_W-1:0]  i_pixel_color,
    input  lcw_pkg::t_q_stat             i_q_stat,
    output logic                         o_push,
    output lcw_pkg::t_cmd                o_cmd
);
    import lcw_pkg::*;

    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(SCREEN_WIDTH);
    localparam logic [COLOR_W-1:0] COLOR_MASK =
        (COLOR_BITS >= COLOR_W) ? {COLOR_W{1'b1}} : COLOR_W'((1 << COLOR_BITS) - 1);

    logic             x_up;
    logic             y_up;
    logic [X_W-1:0]   adx;
    logic [Y_W-1:0]   ady;
    logic             xmaj;
    logic [X_W-1:0]   major;
    logic [ADDR_W-1:0] sy_ext;

    // take a beat whenever the queue has room
    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    // line set-up: deltas, directions and the major axis
    assign x_up   = i_end_x > i_start_x;
    assign y_up   = i_end_y > i_start_y;
    assign adx    = x_up ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
    assign ady    = y_up ? (i_end_y - i_start_y) : (i_start_y - i_end_y);
    assign xmaj   = adx > X_W'(ady);
    assign major  = xmaj ? adx : X_W'(ady);
    assign sy_ext = ADDR_W'(i_start_y);

    // classified item into the queue
    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = t_op'(i_operation);
        o_cmd.x     = i_start_x;
        o_cmd.y     = i_start_y;
        o_cmd.row   = sy_ext * ROW_STEP;
        o_cmd.adx   = adx;
        o_cmd.ady   = ady;
        o_cmd.sxn   = !x_up;
        o_cmd.syn   = !y_up;
        o_cmd.xmaj  = xmaj;
        o_cmd.err   = ERR_W'(major >> 1);
        o_cmd.steps = major;
        o_cmd.color = i_pixel_color & COLOR_MASK;
    end

endmodule

// ===== rtl/lcw_fifo.sv =====
`timescale 1ns / 1ps

module lcw_fifo #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lcw_pkg::t_cmd      i_cmd,
    output lcw_pkg::t_q_stat   o_stat,
    output logic               o_valid,
    output lcw_pkg::t_cmd      o_cmd,
    input  logic               i_pop
);
    import lcw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_stat.full  = r_count == FULL_CNT;
    assign o_stat.empty = r_count == '0;
    assign o_valid      = !o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];

    // occupancy follows push and pop
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && o_stat.full))
        else $error("queue written while full");

    ap_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("queue read while empty");

    ap_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a lone push");

endmodule

// ===== rtl/lcw_back.sv =====
`timescale 1ns / 1ps

module lcw_back #(
    parameter int SCREEN_WIDTH = 320
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [lcw_pkg::BASE_W-1:0]   i_cfg_wr_data,
    input  logic                         i_q_valid,
    input  lcw_pkg::t_cmd                i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lcw_pkg::X_W-1:0]      o_pixel_x,
    output logic [lcw_pkg::Y_W-1:0]      o_pixel_y,
    output logic [lcw_pkg::ADDR_W-1:0]   o_pixel_address,
    output logic [lcw_pkg::COLOR_W-1:0]  o_color,
    output logic                         o_last_pixel
);
    import lcw_pkg::*;

    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(SCREEN_WIDTH);

    // line state
    logic [BASE_W-1:0] r_base;
    logic              r_active;
    logic              r_first;
    logic [X_W-1:0]    r_x;
    logic [Y_W-1:0]    r_y;
    logic [ADDR_W-1:0] r_row;
    logic [X_W-1:0]    r_adx;
    logic [Y_W-1:0]    r_ady;
    logic              r_sxn;
    logic              r_syn;
    logic              r_xmaj;
    logic [ERR_W-1:0]  r_err;
    logic [X_W-1:0]    r_steps;

    // output register
    logic               r_ovalid;
    logic [X_W-1:0]     r_ox;
    logic [Y_W-1:0]     r_oy;
    logic [ADDR_W-1:0]  r_oaddr;
    logic [COLOR_W-1:0] r_ocolor;
    logic               r_olast;

    logic              out_free;
    logic              is_begin;
    logic              emit;
    logic [ERR_W-1:0]  minor_d;
    logic [ERR_W-1:0]  major_d;
    logic [ERR_W-1:0]  err_sum;
    logic              err_ge;
    logic              step_x;
    logic              step_y;
    logic [X_W-1:0]    n_x;
    logic [Y_W-1:0]    n_y;
    logic [ADDR_W-1:0] n_row;
    logic [ERR_W-1:0]  n_err;
    logic [X_W-1:0]    n_steps;
    logic              last;

    // pop when the item can be retired this cycle
    assign out_free = !r_ovalid || i_out_ready;
    assign is_begin = i_q_cmd.op == OP_BEGIN;
    assign o_q_pop  = i_q_valid && (is_begin || !r_active || out_free);
    assign emit     = o_q_pop && !is_begin && r_active;

    // one bresenham step: error update and minor-axis decision
    assign minor_d = r_xmaj ? ERR_W'(r_ady) : ERR_W'(r_adx);
    assign major_d = r_xmaj ? ERR_W'(r_adx) : ERR_W'(r_ady);
    assign err_sum = r_err + minor_d;
    assign err_ge  = err_sum >= major_d;
    assign step_x  = !r_first && (r_xmaj || err_ge);
    assign step_y  = !r_first && (!r_xmaj || err_ge);

    // next position, row offset and counters
    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_row   = r_row;
        n_err   = r_err;
        n_steps = r_steps;
        if (step_x) begin
            n_x = r_sxn ? (r_x - 1'b1) : (r_x + 1'b1);
        end
        if (step_y) begin
            n_y   = r_syn ? (r_y - 1'b1) : (r_y + 1'b1);
            n_row = r_syn ? (r_row - ROW_STEP) : (r_row + ROW_STEP);
        end
        if (!r_first) begin
            n_err   = err_ge ? (err_sum - major_d) : err_sum;
            n_steps = r_steps - 1'b1;
        end
    end

    assign last = n_steps == '0;

    // configuration, line state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_active <= 1'b0;
            r_first  <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_row    <= '0;
            r_adx    <= '0;
            r_ady    <= '0;
            r_sxn    <= 1'b0;
            r_syn    <= 1'b0;
            r_xmaj   <= 1'b0;
            r_err    <= '0;
            r_steps  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            if (o_q_pop && is_begin) begin
                r_active <= 1'b1;
                r_first  <= 1'b1;
                r_x      <= i_q_cmd.x;
                r_y      <= i_q_cmd.y;
                r_row    <= i_q_cmd.row;
                r_adx    <= i_q_cmd.adx;
                r_ady    <= i_q_cmd.ady;
                r_sxn    <= i_q_cmd.sxn;
                r_syn    <= i_q_cmd.syn;
                r_xmaj   <= i_q_cmd.xmaj;
                r_err    <= i_q_cmd.err;
                r_steps  <= i_q_cmd.steps;
            end else if (emit) begin
                r_active <= !last;
                r_first  <= 1'b0;
                r_x      <= n_x;
                r_y      <= n_y;
                r_row    <= n_row;
                r_err    <= n_err;
                r_steps  <= n_steps;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ox     <= n_x;
            r_oy     <= n_y;
            r_oaddr  <= ADDR_W'(r_base) + ADDR_W'(n_x) + n_row;
            r_ocolor <= i_q_cmd.color;
            r_olast  <= last;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_pixel_x       = r_ox;
    assign o_pixel_y       = r_oy;
    assign o_pixel_address = r_oaddr;
    assign o_color         = r_ocolor;
    assign o_last_pixel    = r_olast;

    ap_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> !r_active)
        else $error("line still active after its last pixel");

    ap_err_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_err <= major_d))
        else $error("error accumulator above major delta");

    ap_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> (r_ovalid && $stable(r_oaddr) && $stable(r_olast)))
        else $error("stalled result overwritten");

    ap_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (r_active && i_q_valid && out_free))
        else $error("pixel produced with no line or no room");

endmodule

// ===== rtl/bresenham_color_line_writer_top.sv =====
`timescale 1ns / 1ps
// Line rasteriser that writes a coloured line into a framebuffer.
// Input channel (i_in_valid / o_in_ready): a beat with i_operation = begin
// sets up a line from (i_start_x, i_start_y) to (i_end_x, i_end_y) and
// yields no result; each following colour beat yields one pixel of that
// line, start point first, with o_last_pixel high on the end point. Colour
// beats with no line active are dropped.
// Output channel (o_out_valid / i_out_ready): o_pixel_x, o_pixel_y,
// o_pixel_address = frame base + x + y * SCREEN_WIDTH, o_color.
// Frame base is written through i_cfg_wr_en / i_cfg_wr_data; the user is
// to do so only while idle, the block does not enforce it. Throughput: one
// beat per cycle on both channels while i_out_ready stays high; every pixel
// is one add-and-compare step of the back end. An accepted colour beat is
// held in the two-entry queue, then its pixel in the output register.
// Reset: queue empty, no line active, output invalid, frame base zero.
// Stall: a held result stays put; colour beats of an active line wait, the
// queue fills and o_in_ready drops once both queue entries are taken.
module bresenham_color_line_writer_top #(
    parameter int SCREEN_WIDTH = 320,
    parameter int COLOR_BITS   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [lcw_pkg::BASE_W-1:0]   i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic [lcw_pkg::X_W-1:0]      i_start_x,
    input  logic [lcw_pkg::Y_W-1:0]      i_start_y,
    input  logic [lcw_pkg::X_W-1:0]      i_end_x,
    input  logic [lcw_pkg::Y_W-1:0]      i_end_y,
    input  logic [lcw_pkg::COLOR_W-1:0]  i_pixel_color,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lcw_pkg::X_W-1:0]      o_pixel_x,
    output logic [lcw_pkg::Y_W-1:0]      o_pixel_y,
    output logic [lcw_pkg::ADDR_W-1:0]   o_pixel_address,
    output logic [lcw_pkg::COLOR_W-1:0]  o_color,
    output logic                         o_last_pixel
);
    import lcw_pkg::*;

    t_q_stat q_stat;
    logic    q_push;
    t_cmd    q_in;
    logic    q_valid;
    t_cmd    q_out;
    logic    q_pop;

    // accept and classify
    lcw_front #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .COLOR_BITS   (COLOR_BITS)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_pixel_color (i_pixel_color),
        .i_q_stat      (q_stat),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    // decoupling queue
    lcw_fifo #(
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_stat  (q_stat),
        .o_valid (q_valid),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    // line stepping and pixel output
    lcw_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_q_valid       (q_valid),
        .i_q_cmd         (q_out),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_color         (o_color),
        .o_last_pixel    (o_last_pixel)
    );

endmodule
